// File: src/tpwc_pkg.sv
// package for the thread priority word codec: beat types, codes and class tables
package tpwc_pkg;

    localparam int WORD_W   = 32;
    localparam int CLASS_W  = 8;
    localparam int CODE_W   = 6;
    localparam int LEVEL_W  = 3;
    localparam int LEVELS   = 6;
    localparam int REL_W    = 9;
    localparam int SCHED_W  = 16;

    // word layout
    localparam int LEVEL_LSB    = 8;
    localparam int OVR_LSB      = 14;
    localparam int OVR_FLAG_BIT = 23;
    localparam int EVENT_BIT    = 25;
    localparam int SCHED_BIT    = 29;
    localparam int FLAGS_LSB    = 24;

    localparam logic signed [REL_W-1:0] MIN_RELATIVE = -9'sd15;

    typedef enum logic [1:0] {
        MODE_QOS_ENC   = 2'd0,
        MODE_QOS_DEC   = 2'd1,
        MODE_SCHED_ENC = 2'd2,
        MODE_SCHED_DEC = 2'd3
    } mode_t;

    // input beat payload, last field in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0]       priority_in;
        logic [WORD_W-1:0]       sched_priority;
        logic [7:0]              flag_byte;
        logic signed [7:0]       relative_priority;
        logic [CLASS_W-1:0]      override_class;
        logic [CLASS_W-1:0]      qos_class;
    } in_item_t;

    // result beat payload, last field in the lowest bits
    typedef struct packed {
        logic [1:0]              pad;
        logic                    override_ok;
        logic [SCHED_W-1:0]      sched_out;
        logic [7:0]              flag_byte_out;
        logic signed [REL_W-1:0] relative_out;
        logic [CODE_W-1:0]       override_class_out;
        logic [CODE_W-1:0]       qos_class_out;
        logic [WORD_W-1:0]       priority_out;
    } out_item_t;

    function automatic logic [LEVEL_W-1:0] level_of_class(input logic [CLASS_W-1:0] c);
        logic [LEVEL_W-1:0] lv;
        lv = 3'd0;
        case (c)
            8'h05:   lv = 3'd1;
            8'h09:   lv = 3'd2;
            8'h11:   lv = 3'd3;
            8'h15:   lv = 3'd4;
            8'h19:   lv = 3'd5;
            8'h21:   lv = 3'd6;
            default: lv = 3'd0;
        endcase
        return lv;
    endfunction

    function automatic logic [CODE_W-1:0] class_of_level(input logic [LEVEL_W-1:0] lv);
        logic [CODE_W-1:0] c;
        c = 6'h00;
        case (lv)
            3'd1:    c = 6'h05;
            3'd2:    c = 6'h09;
            3'd3:    c = 6'h11;
            3'd4:    c = 6'h15;
            3'd5:    c = 6'h19;
            3'd6:    c = 6'h21;
            default: c = 6'h00;
        endcase
        return c;
    endfunction

    function automatic logic [LEVELS-1:0] level_onehot(input logic [LEVEL_W-1:0] lv);
        logic [LEVELS-1:0] oh;
        oh = '0;
        case (lv)
            3'd1:    oh = 6'b000001;
            3'd2:    oh = 6'b000010;
            3'd3:    oh = 6'b000100;
            3'd4:    oh = 6'b001000;
            3'd5:    oh = 6'b010000;
            3'd6:    oh = 6'b100000;
            default: oh = '0;
        endcase
        return oh;
    endfunction

    // lowest set bit wins, zero when none
    function automatic logic [LEVEL_W-1:0] lowest_level(input logic [LEVELS-1:0] bits);
        logic [LEVEL_W-1:0] lv;
        lv = 3'd0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (bits[i]) begin
                lv = LEVEL_W'(i + 1);
            end
        end
        return lv;
    endfunction

endpackage

// File: src/tpwc_codec.sv
// combinational encode/decode of one priority word beat
module tpwc_codec
    import tpwc_pkg::*;
(
    input  mode_t     mode,
    input  in_item_t  item,
    output out_item_t result
);

    logic [WORD_W-1:0]       p;
    logic [LEVEL_W-1:0]      enc_lv;
    logic [LEVEL_W-1:0]      enc_ov;
    logic                    clean;
    logic                    has_lv;
    logic                    has_ov;
    logic [LEVEL_W-1:0]      dec_lv;
    logic [LEVEL_W-1:0]      dec_ov;
    logic signed [REL_W-1:0] dec_rel;

    assign p      = item.priority_in;
    assign enc_lv = level_of_class(item.qos_class);
    assign enc_ov = level_of_class(item.override_class);

    // sched or event flag hides level and override
    assign clean   = !p[SCHED_BIT] && !p[EVENT_BIT];
    assign has_lv  = clean && (|p[LEVEL_LSB +: LEVELS]);
    // override field spans bits 21:14, only 19:14 decode to a level
    assign has_ov  = clean && p[OVR_FLAG_BIT] && (|p[OVR_LSB +: 8]);
    assign dec_lv  = has_lv ? lowest_level(p[LEVEL_LSB +: LEVELS]) : '0;
    assign dec_ov  = has_ov ? lowest_level(p[OVR_LSB +: LEVELS]) : '0;
    assign dec_rel = $signed({p[7], p[7:0]}) + 9'sd1;

    always_comb begin
        result = '0;
        case (mode)
            MODE_QOS_ENC: begin
                result.priority_out[FLAGS_LSB +: 8] = item.flag_byte;
                if (enc_lv != '0) begin
                    result.priority_out[LEVEL_LSB +: LEVELS] = level_onehot(enc_lv);
                    result.priority_out[7:0] = 8'(item.relative_priority - 8'sd1);
                end
                if (enc_ov != '0) begin
                    result.priority_out[OVR_LSB +: LEVELS] = level_onehot(enc_ov);
                    result.priority_out[OVR_FLAG_BIT]      = 1'b1;
                end
            end
            MODE_QOS_DEC: begin
                result.qos_class_out      = class_of_level(dec_lv);
                result.override_class_out = class_of_level(dec_ov);
                result.relative_out       = has_lv ? dec_rel : '0;
                result.flag_byte_out      = p[FLAGS_LSB +: 8];
                result.override_ok        = has_lv && (dec_rel <= 9'sd0)
                                            && (dec_rel >= MIN_RELATIVE);
            end
            MODE_SCHED_ENC: begin
                result.priority_out = item.sched_priority;
                result.priority_out[FLAGS_LSB +: 8] = item.flag_byte
                                                      | item.sched_priority[FLAGS_LSB +: 8];
                result.priority_out[SCHED_BIT] = 1'b1;
            end
            MODE_SCHED_DEC: begin
                result.flag_byte_out = p[FLAGS_LSB +: 8];
                result.flag_byte_out[SCHED_BIT - FLAGS_LSB] = 1'b0;
                result.sched_out = p[SCHED_BIT] ? p[SCHED_W-1:0] : '0;
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

// File: src/thread_priority_word_codec.sv
// top level of the thread priority word codec: input stage, codec, result stage
//
// usage
//   s_ channel: one beat per conversion; s_tuser carries the mode
//     (0 qos encode, 1 qos decode, 2 sched encode, 3 sched decode),
//     s_tdata carries the class codes, relative priority, flag byte,
//     scheduler priority and the word to decode
//   m_ channel: one result beat per input beat, same order; fields that
//     the mode does not produce are zero
//   path: an accepted s_ beat is held in the input register, passes the
//     codec and is taken into the result register that drives m_tvalid
//   throughput: one beat per cycle while m_tready is high; the only loop
//     is the two-stage valid/ready chain, the codec itself is combinational
//   stall: while m_tready is low the result register holds its beat and
//     the input register can still take one more beat; s_tready drops
//     only when both stages are full and m_tready is low
//   reset: aresetn low clears both valid flags, so a beat held in either
//     stage is dropped; the payload registers are not reset
module thread_priority_word_codec
    import tpwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    // qos_class, override_class, relative_priority, flag_byte,
    // sched_priority, priority_in
    input  logic [95:0] s_tdata,
    // mode
    input  logic [1:0]  s_tuser,
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // priority_out, qos_class_out, override_class_out, relative_out,
    // flag_byte_out, sched_out, override_ok, two zero bits
    output logic [79:0] m_tdata
);

    // input stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg,  in_item_next;
    mode_t     in_mode_reg,  in_mode_next;

    // result stage
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg,  out_item_next;

    out_item_t codec_result;
    logic      out_advance;

    // result stage moves when empty or its beat is taken
    assign out_advance = !out_valid_reg || m_tready;
    // input stage takes a beat when empty or draining into the result stage
    assign s_tready    = !in_valid_reg || out_advance;

    tpwc_codec u_codec (
        .mode   (in_mode_reg),
        .item   (in_item_reg),
        .result (codec_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        in_mode_next  = in_mode_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_item_next  = in_item_t'(s_tdata);
            in_mode_next  = mode_t'(s_tuser);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_advance) begin
            out_valid_next = in_valid_reg;
            out_item_next  = codec_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        in_mode_reg  <= in_mode_next;
        out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

endmodule

// File: src/tpwc_checker.sv
// port-level checker for the thread priority word codec, bound to the top level
module tpwc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata
);

    // stalled result beat stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // stalled result beat keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat after reset");

    // an encoded word comes with all decode fields zero
    a_encode_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> (m_tdata[79:32] == 48'd0))
        else $error("encode beat carries decode fields");

    // override ok needs a decoded level and a relative of -15 to 0
    a_override_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[77] |->
            (m_tdata[37:32] != 6'd0)
            && ($signed(m_tdata[52:44]) <= 9'sd0)
            && ($signed(m_tdata[52:44]) >= -9'sd15))
        else $error("override ok without a valid level and relative");

endmodule

bind thread_priority_word_codec tpwc_checker u_tpwc_checker (.*);

// File: tb/sv/thread_priority_word_codec_tb.sv
// testbench for the thread priority word codec: directed and random beats checked against a predictor
module thread_priority_word_codec_tb;
    import tpwc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // qos_class, override_class, relative_priority, flag_byte,
    // sched_priority, priority_in
    logic [95:0] s_tdata;
    // mode
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // priority_out, qos_class_out, override_class_out, relative_out,
    // flag_byte_out, sched_out, override_ok, two zero bits
    logic [79:0] m_tdata;

    // predicted result beats, oldest first
    out_item_t pending_results[$];
    int        fail_count;
    // while set neither side inserts idle cycles
    bit        steady;

    thread_priority_word_codec u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // class code tables, kept local to the predictor
    // ---------------------------------------------------------------

    // service level 1..6 for a known class code, 0 for anything else
    function automatic int level_from_code(input logic [7:0] code);
        case (code)
            8'h05:   return 1;
            8'h09:   return 2;
            8'h11:   return 3;
            8'h15:   return 4;
            8'h19:   return 5;
            8'h21:   return 6;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] code_from_level(input int lv);
        case (lv)
            1:       return 8'h05;
            2:       return 8'h09;
            3:       return 8'h11;
            4:       return 8'h15;
            5:       return 8'h19;
            6:       return 8'h21;
            default: return 8'h00;
        endcase
    endfunction

    // lowest set bit of a one-hot level field, counted from 1; 0 when empty
    function automatic int first_level(input logic [5:0] bits);
        int lv;
        lv = 0;
        for (int i = 0; i < 6; i++) begin
            if (bits[i] && lv == 0) begin
                lv = i + 1;
            end
        end
        return lv;
    endfunction

    // ---------------------------------------------------------------
    // predictor: expected result beat for one input beat
    // ---------------------------------------------------------------
    function automatic out_item_t codec_predict(input mode_t md, input in_item_t it);
        out_item_t  res;
        logic [31:0] w;
        int          lv;
        int          ov;
        int          rel;
        bit          clean;
        res = '0;
        w   = it.priority_in;
        case (md)
            MODE_QOS_ENC: begin
                lv = level_from_code(it.qos_class);
                ov = level_from_code(it.override_class);
                res.priority_out = {it.flag_byte, 24'h0};
                // level one-hot plus relative minus one, only for a known class
                if (lv != 0) begin
                    res.priority_out[LEVEL_LSB + lv - 1] = 1'b1;
                    res.priority_out[7:0] = it.relative_priority - 8'd1;
                end
                if (ov != 0) begin
                    res.priority_out[OVR_LSB + ov - 1] = 1'b1;
                    res.priority_out[OVR_FLAG_BIT]     = 1'b1;
                end
            end
            MODE_QOS_DEC: begin
                // sched or event flag hides level and override
                clean = !(w[SCHED_BIT] || w[EVENT_BIT]);
                lv    = (clean && w[13:8] != 0) ? first_level(w[13:8]) : 0;
                // override needs the flag and any bit of 21:14, but only 19:14 decode
                ov    = (clean && w[OVR_FLAG_BIT] && w[21:14] != 0)
                        ? first_level(w[19:14]) : 0;
                rel   = 0;
                if (lv != 0) begin
                    rel = $signed(w[7:0]);
                    rel = rel + 1;
                end
                res.qos_class_out      = 6'(code_from_level(lv));
                res.override_class_out = 6'(code_from_level(ov));
                res.relative_out       = rel[8:0];
                res.flag_byte_out      = w[31:24];
                res.override_ok        = (lv != 0 && rel <= 0 && rel >= -15);
            end
            MODE_SCHED_ENC: begin
                res.priority_out = {it.flag_byte, 24'h0} | it.sched_priority;
                res.priority_out[SCHED_BIT] = 1'b1;
            end
            default: begin
                res.flag_byte_out = w[31:24];
                res.flag_byte_out[SCHED_BIT - FLAGS_LSB] = 1'b0;
                res.sched_out = w[SCHED_BIT] ? w[15:0] : 16'h0;
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_result(input out_item_t want, input logic [79:0] raw);
        out_item_t got;
        got = raw;
        check_field("priority_out",       want.priority_out,            got.priority_out);
        check_field("qos_class_out",      32'(want.qos_class_out),      32'(got.qos_class_out));
        check_field("override_class_out", 32'(want.override_class_out),
                    32'(got.override_class_out));
        check_field("relative_out",       32'(want.relative_out),       32'(got.relative_out));
        check_field("flag_byte_out",      32'(want.flag_byte_out),      32'(got.flag_byte_out));
        check_field("sched_out",          32'(want.sched_out),          32'(got.sched_out));
        check_field("override_ok",        32'(want.override_ok),        32'(got.override_ok));
        check_field("pad",                32'(want.pad),                32'(got.pad));
    endtask

    // every accepted result beat is matched against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                compare_result(pending_results.pop_front(), m_tdata);
            end
        end
    end

    // result side backpressure: m_tready drops at random, with odds of 6 in 100, unless steady
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    // ---------------------------------------------------------------
    // beat driver
    // ---------------------------------------------------------------

    // drive one beat at the falling edge, hold it until accepted, then
    // record its prediction; valid stays high into the next beat unless
    // an idle cycle is drawn
    task automatic send_item(input mode_t md, input in_item_t it);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= md;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(codec_predict(md, it));
    endtask

    function automatic in_item_t make_item(input logic [7:0] qos, input logic [7:0] ovr,
                                           input logic [7:0] rel, input logic [7:0] flags,
                                           input logic [31:0] sched, input logic [31:0] word);
        in_item_t it;
        it.qos_class         = qos;
        it.override_class    = ovr;
        it.relative_priority = rel;
        it.flag_byte         = flags;
        it.sched_priority    = sched;
        it.priority_in       = word;
        return it;
    endfunction

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    task automatic test_qos_encode();
        // lowest and highest class, each with an override
        send_item(MODE_QOS_ENC, make_item(8'h05, 8'h21, 8'h00, 8'h00, '1, '1));
        send_item(MODE_QOS_ENC, make_item(8'h21, 8'h05, 8'h80, 8'hff, '0, '0));
        // unknown class: no level, no relative byte, override still placed
        send_item(MODE_QOS_ENC, make_item(8'h00, 8'h09, 8'h7f, 8'ha5, '0, '0));
        // unknown class and unknown override: flags only
        send_item(MODE_QOS_ENC, make_item(8'hff, 8'hff, 8'hff, 8'h5a, '0, '0));
        send_item(MODE_QOS_ENC, make_item(8'h11, 8'h15, 8'h01, 8'h20, '0, '0));
        send_item(MODE_QOS_ENC, make_item(8'h19, 8'h19, 8'hff, 8'h02, '0, '0));
    endtask

    task automatic test_qos_decode();
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0000_0000));
        // relative 0 and -15: both valid override requests
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0000_01ff));
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0000_20f0));
        // relative -16 falls just outside the override window
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0000_20ef));
        // several level bits, lowest wins; relative +128
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0000_3f7f));
        // sched flag and event flag hide everything but the flag byte
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h20bf_ff00));
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0280_c100));
        // override bits only in 21:20
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h00b0_0100));
        // override level 6 alongside level 1
        send_item(MODE_QOS_DEC, make_item('0, '0, '0, '0, '0, 32'h0088_0100));
        send_item(MODE_QOS_DEC, make_item('1, '1, '1, '1, '1, 32'hffff_ffff));
    endtask

    task automatic test_sched_encode();
        send_item(MODE_SCHED_ENC, make_item('0, '0, '0, 8'h00, 32'h0000_ffff, '0));
        // priority wider than 16 bits goes in unchanged
        send_item(MODE_SCHED_ENC, make_item('0, '0, '0, 8'hff, 32'hffff_ffff, '0));
        send_item(MODE_SCHED_ENC, make_item('0, '0, '0, 8'h5a, 32'h0001_2345, '0));
    endtask

    task automatic test_sched_decode();
        send_item(MODE_SCHED_DEC, make_item('0, '0, '0, '0, '0, 32'hffff_ffff));
        // sched flag clear: no scheduler priority
        send_item(MODE_SCHED_DEC, make_item('0, '0, '0, '0, '0, 32'hdfff_ffff));
        send_item(MODE_SCHED_DEC, make_item('0, '0, '0, '0, '0, 32'h2000_0000));
    endtask

    // ---------------------------------------------------------------
    // random test
    // ---------------------------------------------------------------

    // mostly well-formed words so decode reaches levels, overrides and the
    // override window; the rest is noise on top or fully random
    task automatic test_random(input int count);
        in_item_t  it;
        in_item_t  src;
        mode_t     md;
        int        pick;
        for (int n = 0; n < count; n++) begin
            // a long stretch in the middle runs without idle cycles
            steady = (n >= count / 3 && n < count / 3 + 400);
            it   = {$urandom, $urandom, $urandom};
            md   = mode_t'($urandom_range(3));
            pick = $urandom_range(99);
            case (md)
                MODE_QOS_ENC: begin
                    if (pick < 75) begin
                        it.qos_class = code_from_level($urandom_range(6, 1));
                    end
                    if ($urandom_range(99) < 60) begin
                        it.override_class = code_from_level($urandom_range(6, 1));
                    end
                end
                MODE_QOS_DEC: begin
                    if (pick < 80) begin
                        src = {$urandom, $urandom, $urandom};
                        src.qos_class = code_from_level($urandom_range(6, 1));
                        if ($urandom_range(99) < 60) begin
                            src.override_class = code_from_level($urandom_range(6, 1));
                        end
                        // relative around the override window
                        if ($urandom_range(99) < 70) begin
                            src.relative_priority = 8'($urandom_range(19)) - 8'd17;
                        end
                        if ($urandom_range(99) < 70) begin
                            src.flag_byte[SCHED_BIT - FLAGS_LSB] = 1'b0;
                            src.flag_byte[EVENT_BIT - FLAGS_LSB] = 1'b0;
                        end
                        it.priority_in = codec_predict(MODE_QOS_ENC, src).priority_out;
                        // broken words: stray bits on top of a good one
                        if (pick >= 60) begin
                            it.priority_in = it.priority_in | (32'h1 << $urandom_range(31));
                        end
                    end
                end
                MODE_SCHED_ENC: begin
                    if (pick < 60) begin
                        it.sched_priority = 32'($urandom_range(16'hffff));
                    end
                end
                default: begin
                    if (pick < 60) begin
                        it.priority_in[SCHED_BIT] = 1'b1;
                    end
                end
            endcase
            send_item(md, it);
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        fail_count = 0;
        steady     = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_qos_encode();
        test_qos_decode();
        test_sched_encode();
        test_sched_decode();
        test_random(1500);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        // drain, then a few more cycles to catch any stray result beat
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
